[hw/rtl/wse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wse_pkg: shared types and constants of the wheel speed estimator
// Item and result payloads, configuration set, controller commands and status.
// ----------------------------------------------------------------------------
package wse_pkg;

   // Field widths.
   localparam int TIME_W    = 32;
   localparam int SPEED_W   = 16;
   localparam int TICK_W    = 20;
   localparam int JUMP_W    = 16;
   localparam int TIMEOUT_W = 32;

   // Default ring depth.
   localparam int SAMPLE_COUNT = 10;

   // Micrometres to millimetres per second: distance * 1000 / interval.
   localparam int SCALE_W    = 10;
   localparam int SCALE      = 1000;
   localparam int PROD_W     = TICK_W + SCALE_W;
   localparam int DIV_W      = PROD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_TICK_DISTANCE = 2'd0;
   localparam logic [1:0] REG_JUMP_LIMIT    = 2'd1;
   localparam logic [1:0] REG_TIMEOUT       = 2'd2;

   localparam logic [TICK_W-1:0]    TICK_RESET    = TICK_W'(24300);
   localparam logic [JUMP_W-1:0]    JUMP_RESET    = JUMP_W'(1000);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(50000);

   // Item actions.
   localparam logic ACT_EDGE  = 1'b0;
   localparam logic ACT_CHECK = 1'b1;

   typedef struct packed {
      logic              action;
      logic              wheel;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic               wheel_out;
      logic [SPEED_W-1:0] speed_mm_s;
      logic               sample_taken;
      logic               speed_changed;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0]    tick_distance_um;
      logic [JUMP_W-1:0]    jump_limit_mm_s;
      logic [TIMEOUT_W-1:0] timeout_us;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LOAD_SPEED,
      ST_DIV_SPEED,
      ST_STORE,
      ST_MEAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_item;
      logic prep;
      logic div_load_speed;
      logic div_step;
      logic store_sample;
      logic calc_mean;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic edge_seen;
      logic div_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/wheel_speed_estimator.sv]
`default_nettype none
// Sequence: a timeout check or a first edge goes from decode straight to the result hand-off;
// a measuring edge first runs the bit-serial divider once for the interval division,
// then the ring update and the ring mean; the ring mean is one reciprocal multiply.
// Throughput: one item at a time; a new beat can be taken once the result is
// registered, while that result may still wait on the output.
// Reset is synchronous; control, configuration and per-wheel state and the ring valid bits clear.
// ----------------------------------------------------------------------------
// wheel_speed_estimator: two-wheel period-based speed estimator
// Register file on the configuration port, sequencer and datapath.
// ----------------------------------------------------------------------------
module wheel_speed_estimator #(
   parameter int SampleCount = wse_pkg::SAMPLE_COUNT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire wse_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output wse_pkg::rsp_type                       rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [wse_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [wse_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [wse_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);

   wse_pkg::cfg_type    cfg_ff;
   wse_pkg::cmd_type    cmd;
   wse_pkg::status_type status;
   logic                csr_write;
   logic [1:0]          csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_distance_um <= wse_pkg::TICK_RESET;
         cfg_ff.jump_limit_mm_s  <= wse_pkg::JUMP_RESET;
         cfg_ff.timeout_us       <= wse_pkg::TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            wse_pkg::REG_TICK_DISTANCE: begin
               cfg_ff.tick_distance_um <= pwdata[wse_pkg::TICK_W-1:0];
            end
            wse_pkg::REG_JUMP_LIMIT: begin
               cfg_ff.jump_limit_mm_s <= pwdata[wse_pkg::JUMP_W-1:0];
            end
            wse_pkg::REG_TIMEOUT: begin
               cfg_ff.timeout_us <= pwdata[wse_pkg::TIMEOUT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         wse_pkg::REG_TICK_DISTANCE: prdata = wse_pkg::CSR_DATA_W'(cfg_ff.tick_distance_um);
         wse_pkg::REG_JUMP_LIMIT:    prdata = wse_pkg::CSR_DATA_W'(cfg_ff.jump_limit_mm_s);
         wse_pkg::REG_TIMEOUT:       prdata = wse_pkg::CSR_DATA_W'(cfg_ff.timeout_us);
         default:                    prdata = '0;
      endcase
   end

   wse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wse_dp #(
      .SampleCount (SampleCount)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A taken beat keeps the input side busy until its result is registered.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again before the previous item finished");

   // A change without a new sample can only be a timeout, which forces zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.speed_changed && !rsp_data.sample_taken)
         |-> (rsp_data.speed_mm_s == '0))
      else $error("speed changed without a sample but is not zero");

   // A fresh result only follows a cycle in which the block was busy.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

endmodule
`default_nettype wire

[hw/rtl/wse_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wse_ctrl: sequencer of the wheel speed estimator
// Steps one item through decode, speed division, ring update, ring mean
// and result hand-off.
// ----------------------------------------------------------------------------
module wse_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire wse_pkg::status_type status,
   output wse_pkg::cmd_type         cmd
);

   wse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         wse_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = wse_pkg::ST_DECIDE;
            end
         end
         wse_pkg::ST_DECIDE: begin
            // Timeout checks and first edges need no division.
            if (status.action == wse_pkg::ACT_CHECK || !status.edge_seen) begin
               state_in = wse_pkg::ST_FINISH;
            end else begin
               cmd.prep = 1'b1;
               state_in = wse_pkg::ST_LOAD_SPEED;
            end
         end
         wse_pkg::ST_LOAD_SPEED: begin
            cmd.div_load_speed = 1'b1;
            state_in           = wse_pkg::ST_DIV_SPEED;
         end
         wse_pkg::ST_DIV_SPEED: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = wse_pkg::ST_STORE;
            end
         end
         wse_pkg::ST_STORE: begin
            cmd.store_sample = 1'b1;
            state_in         = wse_pkg::ST_MEAN;
         end
         wse_pkg::ST_MEAN: begin
            cmd.calc_mean = 1'b1;
            state_in      = wse_pkg::ST_FINISH;
         end
         wse_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = wse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wse_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/wse_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wse_dp: datapath of the wheel speed estimator
// Per-wheel edge state, sample ring with running sums, restoring divider for
// the interval, reciprocal multiply for the ring mean and the result register.
// ----------------------------------------------------------------------------
module wse_dp #(
   parameter int SampleCount = wse_pkg::SAMPLE_COUNT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wse_pkg::cfg_type    cfg,
   input  wire wse_pkg::req_type    req_data,
   input  wire wse_pkg::cmd_type    cmd,
   output wse_pkg::status_type      status,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output wse_pkg::rsp_type         rsp_data
);

   localparam int POS_W  = (SampleCount > 1) ? $clog2(SampleCount) : 1;
   localparam int DEPTH  = 2 * SampleCount;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = wse_pkg::SPEED_W + $clog2(SampleCount + 1);
   localparam int TW     = wse_pkg::TIME_W;
   localparam int SW     = wse_pkg::SPEED_W;
   localparam int DW     = wse_pkg::DIV_W;

   // The mean is sum * RCP >> RCP_SHIFT, with RCP rounded up. That is exact for
   // every sum below 2^SUM_W.
   localparam int RCP_SHIFT = SUM_W + $clog2(SampleCount);
   localparam int RCP_W     = SUM_W + 1;
   localparam int MPROD_W   = SUM_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((64'd1 << RCP_SHIFT) + 64'(SampleCount) - 64'd1) / 64'(SampleCount));

   // Latched item.
   logic          act_ff;
   logic          whl_ff;
   logic [TW-1:0] time_ff;

   // Per-wheel state.
   logic [TW-1:0]    last_ff [2];
   logic [1:0]       seen_ff;
   logic [POS_W-1:0] pos_ff  [2];
   logic [SW-1:0]    filt_ff [2];
   logic [SUM_W-1:0] sum_ff  [2];

   // Sample ring; an entry not yet written reads as zero.
   logic [SW-1:0]    ring_mem [DEPTH];
   logic [DEPTH-1:0] ring_vld_ff;
   logic [SW-1:0]    rd_data_ff;
   logic             rd_vld_ff;

   // Divider.
   logic [wse_pkg::PROD_W-1:0]    prod_ff;
   logic [TW-1:0]                 rem_ff;
   logic [DW-1:0]                 quo_ff;
   logic [TW-1:0]                 dsr_ff;
   logic [wse_pkg::DIV_CNT_W-1:0] cnt_ff;

   // Ring mean.
   logic [SW-1:0] mean_ff;

   // Result register.
   logic             out_vld_ff;
   wse_pkg::rsp_type out_ff;

   logic [ADDR_W-1:0]  addr;
   logic [TW-1:0]      age;
   logic [SW-1:0]      old_sample;
   logic [SW-1:0]      sample;
   logic [SUM_W-1:0]   sum_in;
   logic [POS_W-1:0]   pos_in;
   logic [TW:0]        trial;
   logic               trial_ge;
   logic [MPROD_W-1:0] mean_prod;
   logic [SW-1:0]      mean;
   logic [SW:0]        limit;
   logic [SW-1:0]      filt_in;
   logic               taken_in;
   logic               changed_in;
   logic               out_free;

   assign addr = whl_ff ? ADDR_W'(SampleCount) + ADDR_W'(pos_ff[1])
                        : ADDR_W'(pos_ff[0]);
   assign age        = time_ff - last_ff[whl_ff];
   assign old_sample = rd_vld_ff ? rd_data_ff : '0;
   // Quotients above the speed range saturate.
   assign sample     = (|quo_ff[DW-1:SW]) ? {SW{1'b1}} : quo_ff[SW-1:0];
   assign sum_in     = sum_ff[whl_ff] - SUM_W'(old_sample) + SUM_W'(sample);
   assign pos_in     = (pos_ff[whl_ff] == POS_W'(SampleCount - 1)) ? '0
                                                                  : pos_ff[whl_ff] + POS_W'(1);

   assign trial    = {rem_ff, quo_ff[DW-1]};
   assign trial_ge = trial >= {1'b0, dsr_ff};

   assign mean_prod = MPROD_W'(sum_ff[whl_ff]) * MPROD_W'(RCP);

   assign mean  = mean_ff;
   assign limit = {1'b0, filt_ff[whl_ff]} + {1'b0, cfg.jump_limit_mm_s};

   always_comb begin
      filt_in    = filt_ff[whl_ff];
      taken_in   = 1'b0;
      changed_in = 1'b0;
      if (act_ff == wse_pkg::ACT_EDGE) begin
         if (seen_ff[whl_ff]) begin
            taken_in = 1'b1;
            if ({1'b0, mean} < limit) begin
               filt_in    = mean;
               changed_in = 1'b1;
            end
         end
      end else if (seen_ff[whl_ff] && age > cfg.timeout_us) begin
         filt_in    = '0;
         changed_in = 1'b1;
      end
   end

   assign out_free = !out_vld_ff || !rsp_stall;

   assign status.action    = act_ff;
   assign status.edge_seen = seen_ff[whl_ff];
   assign status.div_last  = cnt_ff == wse_pkg::DIV_CNT_W'(1);
   assign status.out_free  = out_free;

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         last_ff[0]  <= '0;
         last_ff[1]  <= '0;
         pos_ff[0]   <= '0;
         pos_ff[1]   <= '0;
         filt_ff[0]  <= '0;
         filt_ff[1]  <= '0;
         sum_ff[0]   <= '0;
         sum_ff[1]   <= '0;
         ring_vld_ff <= '0;
         cnt_ff      <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (cmd.store_sample) begin
            ring_vld_ff[addr] <= 1'b1;
            sum_ff[whl_ff]    <= sum_in;
            pos_ff[whl_ff]    <= pos_in;
         end
         if (cmd.finish) begin
            filt_ff[whl_ff] <= filt_in;
            if (act_ff == wse_pkg::ACT_EDGE) begin
               last_ff[whl_ff] <= time_ff;
               seen_ff[whl_ff] <= 1'b1;
            end
         end
         if (cmd.div_load_speed) begin
            cnt_ff <= wse_pkg::DIV_CNT_W'(DW);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - wse_pkg::DIV_CNT_W'(1);
         end
         if (cmd.finish) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         act_ff  <= req_data.action;
         whl_ff  <= req_data.wheel;
         time_ff <= req_data.time_us;
      end
      if (cmd.prep) begin
         prod_ff <= wse_pkg::PROD_W'(cfg.tick_distance_um) *
                    wse_pkg::PROD_W'(wse_pkg::SCALE);
      end
      if (cmd.div_load_speed) begin
         rem_ff <= '0;
         quo_ff <= prod_ff;
         dsr_ff <= age;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? TW'(trial - {1'b0, dsr_ff}) : trial[TW-1:0];
         quo_ff <= {quo_ff[DW-2:0], trial_ge};
      end
      if (cmd.calc_mean) begin
         mean_ff <= mean_prod[RCP_SHIFT +: SW];
      end
      if (cmd.finish) begin
         out_ff.wheel_out     <= whl_ff;
         out_ff.speed_mm_s    <= filt_in;
         out_ff.sample_taken  <= taken_in;
         out_ff.speed_changed <= changed_in;
      end
   end

   // Ring memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.store_sample) begin
         ring_mem[addr] <= sample;
      end
      if (cmd.prep) begin
         rd_data_ff <= ring_mem[addr];
         rd_vld_ff  <= ring_vld_ff[addr];
      end
   end

endmodule
`default_nettype wire

[tb/tb_wheel_speed_estimator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wheel_speed_estimator: self-checking bench of the two-wheel speed estimator
// Drives sensor edges and timeout checks through the request channel, keeps its
// own model of the rings and filtered speeds, and compares every result beat.
// ----------------------------------------------------------------------------
module tb_wheel_speed_estimator;

   localparam int CYCLE_LIMIT     = 2000000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 238;
   localparam int DRAIN_CYCLES    = 80;
   localparam int DIRECTED_ROWS   = 20;

   typedef struct packed {
      logic                       action;
      logic                       wheel;
      logic [wse_pkg::TIME_W-1:0] time_us;
      logic                       known;
      wse_pkg::rsp_type           result;
   } probe_row_type;

   // Rows with known set carry a result that follows directly from the reset
   // configuration; the others are checked against the speed model.
   probe_row_type probe_rows [DIRECTED_ROWS] = '{
      '{wse_pkg::ACT_CHECK, 1'b0, 32'd0,        1'b1, '{1'b0, 16'd0,  1'b0, 1'b0}},
      '{wse_pkg::ACT_CHECK, 1'b1, 32'hFFFFFFFF, 1'b1, '{1'b1, 16'd0,  1'b0, 1'b0}},
      '{wse_pkg::ACT_EDGE,  1'b0, 32'd1000,     1'b1, '{1'b0, 16'd0,  1'b0, 1'b0}},
      '{wse_pkg::ACT_EDGE,  1'b0, 32'd1000,     1'b1, '{1'b0, 16'd0,  1'b1, 1'b0}},
      '{wse_pkg::ACT_EDGE,  1'b0, 32'd999,      1'b1, '{1'b0, 16'd0,  1'b1, 1'b0}},
      '{wse_pkg::ACT_CHECK, 1'b0, 32'd50999,    1'b1, '{1'b0, 16'd0,  1'b0, 1'b0}},
      '{wse_pkg::ACT_CHECK, 1'b0, 32'd51000,    1'b1, '{1'b0, 16'd0,  1'b0, 1'b1}},
      '{wse_pkg::ACT_CHECK, 1'b0, 32'd51000,    1'b1, '{1'b0, 16'd0,  1'b0, 1'b1}},
      '{wse_pkg::ACT_EDGE,  1'b1, 32'hFFFFFFF0, 1'b1, '{1'b1, 16'd0,  1'b0, 1'b0}},
      '{wse_pkg::ACT_EDGE,  1'b1, 32'h0000BDC8, 1'b1, '{1'b1, 16'd50, 1'b1, 1'b1}},
      '{wse_pkg::ACT_EDGE,  1'b1, 32'd72884,    1'b0, '0},
      '{wse_pkg::ACT_EDGE,  1'b1, 32'd73255,    1'b0, '0},
      '{wse_pkg::ACT_CHECK, 1'b1, 32'd123254,   1'b0, '0},
      '{wse_pkg::ACT_EDGE,  1'b1, 32'd173255,   1'b0, '0},
      '{wse_pkg::ACT_EDGE,  1'b0, 32'd25299,    1'b0, '0},
      '{wse_pkg::ACT_CHECK, 1'b1, 32'hFFFFFFFF, 1'b0, '0},
      '{wse_pkg::ACT_EDGE,  1'b0, 32'd25300,    1'b0, '0},
      '{wse_pkg::ACT_CHECK, 1'b0, 32'd0,        1'b0, '0},
      '{wse_pkg::ACT_EDGE,  1'b1, 32'hFFFFFFFF, 1'b0, '0},
      '{wse_pkg::ACT_EDGE,  1'b1, 32'hFFFFFFFF, 1'b0, '0}
   };

   logic                           clock;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   wse_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   wse_pkg::rsp_type               rsp_data;
   logic                           psel      = 1'b0;
   logic                           penable   = 1'b0;
   logic                           pwrite    = 1'b0;
   logic [wse_pkg::CSR_ADDR_W-1:0] paddr     = '0;
   logic [wse_pkg::CSR_DATA_W-1:0] pwdata    = '0;
   logic [wse_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   // Speed model: configuration and per-wheel state.
   logic [wse_pkg::TICK_W-1:0]    cfg_tick    = wse_pkg::TICK_RESET;
   logic [wse_pkg::JUMP_W-1:0]    cfg_jump    = wse_pkg::JUMP_RESET;
   logic [wse_pkg::TIMEOUT_W-1:0] cfg_timeout = wse_pkg::TIMEOUT_RESET;
   logic [wse_pkg::TIME_W-1:0]    edge_time [2];
   logic                          edge_valid [2];
   logic [wse_pkg::SPEED_W-1:0]   ring_speeds [2][wse_pkg::SAMPLE_COUNT];
   int                            ring_pos [2];
   logic [wse_pkg::SPEED_W-1:0]   filt_speed [2];

   wse_pkg::rsp_type speed_reports_due [$];
   int               err_count   = 0;
   int               cycle_count = 0;
   bit               src_idle    = 1'b1;
   bit               sink_idle   = 1'b1;

   wheel_speed_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      for (int w = 0; w < 2; w++) begin
         edge_time[w]  = '0;
         edge_valid[w] = 1'b0;
         ring_pos[w]   = 0;
         filt_speed[w] = '0;
         for (int i = 0; i < wse_pkg::SAMPLE_COUNT; i++) ring_speeds[w][i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Applies one item to the model and returns the result it should produce.
   function automatic wse_pkg::rsp_type estimate_speed(wse_pkg::req_type it);
      wse_pkg::rsp_type rep;
      logic [31:0]      age;
      logic [63:0]      quot;
      logic [31:0]      ring_sum;
      logic [15:0]      mean;
      int               w;
      w   = it.wheel;
      age = it.time_us - edge_time[w];
      rep = '0;
      rep.wheel_out = it.wheel;
      if (it.action == wse_pkg::ACT_EDGE) begin
         if (edge_valid[w]) begin
            if (age == 0) begin
               quot = 64'd65535;
            end else begin
               quot = (64'(cfg_tick) * 64'd1000) / 64'(age);
               if (quot > 64'd65535) quot = 64'd65535;
            end
            ring_speeds[w][ring_pos[w]] = quot[15:0];
            ring_pos[w] = (ring_pos[w] == wse_pkg::SAMPLE_COUNT - 1) ? 0 : ring_pos[w] + 1;
            ring_sum = '0;
            for (int i = 0; i < wse_pkg::SAMPLE_COUNT; i++) begin
               ring_sum += 32'(ring_speeds[w][i]);
            end
            mean = 16'(ring_sum / wse_pkg::SAMPLE_COUNT);
            rep.sample_taken = 1'b1;
            if (32'(mean) < 32'(filt_speed[w]) + 32'(cfg_jump)) begin
               filt_speed[w]     = mean;
               rep.speed_changed = 1'b1;
            end
         end
         edge_time[w]  = it.time_us;
         edge_valid[w] = 1'b1;
      end else if (edge_valid[w] && age > cfg_timeout) begin
         filt_speed[w]     = '0;
         rep.speed_changed = 1'b1;
      end
      rep.speed_mm_s = filt_speed[w];
      return rep;
   endfunction

   // Random sensor traffic: intervals mostly sized for plausible speeds, with
   // zero, tiny, huge and timeout-sized intervals mixed in.
   function automatic wse_pkg::req_type next_wheel_event();
      wse_pkg::req_type it;
      logic [31:0]      span;
      logic [63:0]      period;
      it.wheel  = 1'($urandom_range(0, 1));
      it.action = ($urandom_range(0, 3) == 0) ? wse_pkg::ACT_CHECK : wse_pkg::ACT_EDGE;
      if (it.action == wse_pkg::ACT_EDGE) begin
         case ($urandom_range(0, 11))
            0: span = $urandom_range(0, 2);
            1: span = $urandom();
            2: span = cfg_timeout + $urandom_range(0, 2) - 1;
            default: begin
               period = (64'(cfg_tick) * 64'd1000) /
                        64'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 70000 : 2500));
               span = (period == 0) ? $urandom_range(1, 5000) : period[31:0];
            end
         endcase
      end else begin
         case ($urandom_range(0, 3))
            0: span = cfg_timeout;
            1: span = cfg_timeout + 1;
            2: span = $urandom_range(0, cfg_timeout);
            default: span = $urandom();
         endcase
      end
      it.time_us = edge_time[it.wheel] + span;
      return it;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         wse_pkg::REG_TICK_DISTANCE: cfg_tick    = value[wse_pkg::TICK_W-1:0];
         wse_pkg::REG_JUMP_LIMIT:    cfg_jump    = value[wse_pkg::JUMP_W-1:0];
         wse_pkg::REG_TIMEOUT:       cfg_timeout = value[wse_pkg::TIMEOUT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic put_item(input wse_pkg::req_type it, input logic known,
                           input wse_pkg::rsp_type typed);
      wse_pkg::rsp_type predicted;
      if (src_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      predicted = estimate_speed(it);
      speed_reports_due.push_back(known ? typed : predicted);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (sink_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      wse_pkg::rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (speed_reports_due.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_data);
            err_count++;
         end else begin
            due = speed_reports_due.pop_front();
            if (rsp_data.wheel_out !== due.wheel_out) begin
               $error("wheel_out: expected %0d, got %0d", due.wheel_out, rsp_data.wheel_out);
               err_count++;
            end
            if (rsp_data.speed_mm_s !== due.speed_mm_s) begin
               $error("speed_mm_s: expected %0d, got %0d", due.speed_mm_s,
                      rsp_data.speed_mm_s);
               err_count++;
            end
            if (rsp_data.sample_taken !== due.sample_taken) begin
               $error("sample_taken: expected %0d, got %0d", due.sample_taken,
                      rsp_data.sample_taken);
               err_count++;
            end
            if (rsp_data.speed_changed !== due.speed_changed) begin
               $error("speed_changed: expected %0d, got %0d", due.speed_changed,
                      rsp_data.speed_changed);
               err_count++;
            end
         end
      end
   end

   initial begin
      wse_pkg::req_type           it;
      logic [wse_pkg::TICK_W-1:0] tick_v;
      logic [wse_pkg::JUMP_W-1:0] jump_v;
      logic [31:0]                timeout_v;
      while (reset) @(posedge clock);
      @(posedge clock);

      foreach (probe_rows[i]) begin
         it.action  = probe_rows[i].action;
         it.wheel   = probe_rows[i].wheel;
         it.time_us = probe_rows[i].time_us;
         put_item(it, probe_rows[i].known, probe_rows[i].result);
      end
      req_valid <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         while (speed_reports_due.size() != 0) @(posedge clock);
         case (ph)
            0: begin tick_v = 20'd24300;  jump_v = 16'd1000;  timeout_v = 32'd50000;    end
            1: begin tick_v = 20'd1;      jump_v = 16'd0;     timeout_v = 32'd1;        end
            2: begin tick_v = 20'd1000000; jump_v = 16'hFFFF; timeout_v = 32'hFFFFFFFF; end
            3: begin tick_v = 20'hFFFFF;  jump_v = 16'hFFFF;  timeout_v = 32'd0;        end
            4: begin tick_v = 20'd0;      jump_v = 16'd500;   timeout_v = 32'd1000;     end
            5: begin
               tick_v    = 20'($urandom_range(1, 1000000));
               jump_v    = 16'($urandom_range(0, 65535));
               timeout_v = $urandom_range(1, 1000000);
            end
            6: begin
               tick_v    = 20'($urandom());
               jump_v    = 16'($urandom());
               timeout_v = $urandom();
            end
            default: begin tick_v = 20'd24300; jump_v = 16'd2000; timeout_v = 32'd200000; end
         endcase
         write_reg(wse_pkg::REG_TICK_DISTANCE, 32'(tick_v));
         write_reg(wse_pkg::REG_JUMP_LIMIT, 32'(jump_v));
         write_reg(wse_pkg::REG_TIMEOUT, timeout_v);
         // The closing phase runs at full rate on both sides.
         src_idle  = (ph != PHASES - 1);
         sink_idle = (ph != PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) put_item(next_wheel_event(), 1'b0, '0);
         req_valid <= 1'b0;
      end

      while (speed_reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/wse_pkg.sv
hw/rtl/wse_ctrl.sv
hw/rtl/wse_dp.sv
hw/rtl/wheel_speed_estimator.sv
tb/tb_wheel_speed_estimator.sv
